// ===== src/pu2x_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pu2x_pkg
// Shared widths, codes and defaults of the 2x bilinear pixel upscaler.
// ----------------------------------------------------------------------------
package pu2x_pkg;

    localparam int PIX_W          = 32;    // RGBA word
    localparam int CFG_W          = 11;    // width and height registers
    localparam int COORD_W        = 10;    // src_col / src_row fields
    localparam int MAX_WIDTH_DEF  = 1024;  // default line store depth
    localparam int MAX_HEIGHT     = 1024;

    localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(480);

    // configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // input operation codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

endpackage

// ===== src/pu2x_line_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pu2x_line_ram
// One source line store: one write port, two registered read ports that
// load together when enabled and hold otherwise.
// ----------------------------------------------------------------------------
module pu2x_line_ram #(
    parameter int DEPTH = pu2x_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(pu2x_pkg::MAX_WIDTH_DEF)
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [pu2x_pkg::PIX_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr0,
    input  logic [AW-1:0]              rd_addr1,
    output logic [pu2x_pkg::PIX_W-1:0] rd_data0,
    output logic [pu2x_pkg::PIX_W-1:0] rd_data1
);

    logic [pu2x_pkg::PIX_W-1:0] mem [DEPTH];
    logic [pu2x_pkg::PIX_W-1:0] rd_data0_reg;
    logic [pu2x_pkg::PIX_W-1:0] rd_data1_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read-first: a read at the written address returns the old entry
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data0_reg <= mem[rd_addr0];
            rd_data1_reg <= mem[rd_addr1];
        end
    end

    assign rd_data0 = rd_data0_reg;
    assign rd_data1 = rd_data1_reg;

endmodule

// ===== src/pixel_upscale_2x_interp_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_upscale_2x_interp_unit
// 2x bilinear upscaler: one 2x2 RGBA block per source pixel, emitted one
// row late from two line stores; flush requests drain the last row.
//
//   channel   direction  handshake       payload
//   s_        in         s_valid/ready   operation, pixel_rgba
//   m_        out        m_valid/ready   src_col, src_row, 4 x RGBA, flags
//   cfg_      in         cfg_we          cfg_index, cfg_data
//
// One request per cycle sustained while m_ does not stall; a block reaches m_
// through the line store read, then the mix and output register.
// The line stores are read at column x and x+1 in the same cycle; the left
// neighbour is the previous block's centre, held in a register.
// Reset clears counters and valids and sets the default size; no clearing pass over the stores.
// A stall on m_ holds one block in the mix stage and one at the output.
// ----------------------------------------------------------------------------
module pixel_upscale_2x_interp_unit #(
    parameter int MAX_WIDTH = pu2x_pkg::MAX_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [pu2x_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_operation,
    input  logic [pu2x_pkg::PIX_W-1:0]   s_pixel_rgba,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [pu2x_pkg::COORD_W-1:0] m_src_col,
    output logic [pu2x_pkg::COORD_W-1:0] m_src_row,
    output logic [pu2x_pkg::PIX_W-1:0]   m_top_left,
    output logic [pu2x_pkg::PIX_W-1:0]   m_top_right,
    output logic [pu2x_pkg::PIX_W-1:0]   m_bottom_left,
    output logic [pu2x_pkg::PIX_W-1:0]   m_bottom_right,
    output logic                         m_on_border,
    output logic                         m_frame_last
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = (AW + 1 > pu2x_pkg::CFG_W) ? AW + 1 : pu2x_pkg::CFG_W;
    localparam int HW = pu2x_pkg::CFG_W;
    localparam int CO = pu2x_pkg::COORD_W;
    localparam int PW = pu2x_pkg::PIX_W;

    function automatic logic [PW-1:0] mix4(input logic [PW-1:0] p,
                                           input logic [PW-1:0] a,
                                           input logic [PW-1:0] b);
        logic [PW-1:0] r;
        logic [9:0]    s;
        r = '0;
        for (int i = 0; i < 4; i++) begin
            s = {1'b0, p[8*i +: 8], 1'b0} + {2'b00, a[8*i +: 8]} + {2'b00, b[8*i +: 8]};
            r[8*i +: 8] = s[9:2];
        end
        return r;
    endfunction

    // configuration and counters
    logic [HW-1:0] width_reg;
    logic [HW-1:0] height_reg;
    logic [AW-1:0] in_col_reg;
    logic [HW-1:0] in_row_reg;
    logic [AW-1:0] out_col_reg;
    logic [CO-1:0] out_row_reg;
    logic          frame_done_reg;

    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;

    always_comb begin
        eff_w = WW'(width_reg);
        if (eff_w == '0) begin
            eff_w = WW'(1);
        end else if (eff_w > WW'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end
        eff_h = height_reg;
        if (eff_h == '0) begin
            eff_h = HW'(1);
        end else if (eff_h > HW'(pu2x_pkg::MAX_HEIGHT)) begin
            eff_h = HW'(pu2x_pkg::MAX_HEIGHT);
        end
    end

    // request decode
    logic          out_adv;
    logic          accept;
    logic          is_flush;
    logic          emit;
    logic          store_wr;
    logic          x_last;
    logic          y_last;
    logic          blk_border;
    logic          blk_last;
    logic          in_col_wrap;
    logic          in_row_wrap;
    logic [AW-1:0] col_right;

    logic s1_valid_reg;
    logic m_valid_reg;

    assign out_adv  = !m_valid_reg || m_ready;
    assign s_ready  = !s1_valid_reg || out_adv;
    assign accept   = s_valid && s_ready;
    assign is_flush = (s_operation == pu2x_pkg::OP_FLUSH);
    assign emit     = accept && (is_flush ? frame_done_reg
                                          : (!frame_done_reg && in_row_reg != '0));
    assign store_wr = accept && !is_flush && !frame_done_reg;

    assign x_last      = (WW'(out_col_reg) + WW'(1)) >= eff_w;
    assign y_last      = (HW'(out_row_reg) + HW'(1)) >= eff_h;
    assign blk_border  = (out_col_reg == '0) || x_last || (out_row_reg == '0) || y_last;
    assign blk_last    = x_last && y_last;
    assign in_col_wrap = (WW'(in_col_reg) + WW'(1)) >= eff_w;
    assign in_row_wrap = (in_row_reg + HW'(1)) >= eff_h;
    assign col_right   = out_col_reg + AW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg      <= pu2x_pkg::WIDTH_RST;
            height_reg     <= pu2x_pkg::HEIGHT_RST;
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            frame_done_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pu2x_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                pu2x_pkg::REG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            frame_done_reg <= 1'b0;
        end else begin
            if (store_wr) begin
                if (in_col_wrap) begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + HW'(1);
                    if (in_row_wrap) begin
                        frame_done_reg <= 1'b1;
                    end
                end else begin
                    in_col_reg <= in_col_reg + AW'(1);
                end
            end
            if (emit) begin
                if (blk_last) begin
                    // frame complete: back to the start
                    in_col_reg     <= '0;
                    in_row_reg     <= '0;
                    out_col_reg    <= '0;
                    out_row_reg    <= '0;
                    frame_done_reg <= 1'b0;
                end else if (x_last) begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + CO'(1);
                end else begin
                    out_col_reg <= out_col_reg + AW'(1);
                end
            end
        end
    end

    // line stores: even rows in a, odd rows in b
    logic [PW-1:0] a_rd0;
    logic [PW-1:0] a_rd1;
    logic [PW-1:0] b_rd0;
    logic [PW-1:0] b_rd1;

    pu2x_line_ram #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_store_a (
        .aclk     (aclk),
        .wr_en    (store_wr && !in_row_reg[0]),
        .wr_addr  (in_col_reg),
        .wr_data  (s_pixel_rgba),
        .rd_en    (emit),
        .rd_addr0 (out_col_reg),
        .rd_addr1 (col_right),
        .rd_data0 (a_rd0),
        .rd_data1 (a_rd1)
    );

    pu2x_line_ram #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_store_b (
        .aclk     (aclk),
        .wr_en    (store_wr && in_row_reg[0]),
        .wr_addr  (in_col_reg),
        .wr_data  (s_pixel_rgba),
        .rd_en    (emit),
        .rd_addr0 (out_col_reg),
        .rd_addr1 (col_right),
        .rd_data0 (b_rd0),
        .rd_data1 (b_rd1)
    );

    // mix stage: store read data arrives here
    logic [AW-1:0] s1_col_reg;
    logic [CO-1:0] s1_row_reg;
    logic          s1_border_reg;
    logic          s1_last_reg;
    logic          s1_sel_reg;
    logic [PW-1:0] s1_down_reg;
    logic [PW-1:0] left_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (emit) begin
            s1_valid_reg <= 1'b1;
        end else if (out_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            s1_col_reg    <= out_col_reg;
            s1_row_reg    <= out_row_reg;
            s1_border_reg <= blk_border;
            s1_last_reg   <= blk_last;
            s1_sel_reg    <= out_row_reg[0];
            s1_down_reg   <= s_pixel_rgba;
        end
    end

    logic [PW-1:0] center;
    logic [PW-1:0] right;
    logic [PW-1:0] up;
    logic [CO+AW-1:0] col_ext;

    assign center  = s1_sel_reg ? b_rd0 : a_rd0;
    assign up      = s1_sel_reg ? a_rd0 : b_rd0;
    assign right   = s1_sel_reg ? b_rd1 : a_rd1;
    assign col_ext = {{CO{1'b0}}, s1_col_reg};

    // output register
    logic [CO-1:0] m_col_reg;
    logic [CO-1:0] m_row_reg;
    logic [PW-1:0] m_tl_reg;
    logic [PW-1:0] m_tr_reg;
    logic [PW-1:0] m_bl_reg;
    logic [PW-1:0] m_br_reg;
    logic          m_border_reg;
    logic          m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_adv) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && s1_valid_reg) begin
            // keep this centre as the next block's left neighbour
            left_reg     <= center;
            m_col_reg    <= col_ext[CO-1:0];
            m_row_reg    <= s1_row_reg;
            m_border_reg <= s1_border_reg;
            m_last_reg   <= s1_last_reg;
            if (s1_border_reg) begin
                m_tl_reg <= center;
                m_tr_reg <= center;
                m_bl_reg <= center;
                m_br_reg <= center;
            end else begin
                m_tl_reg <= mix4(center, left_reg, s1_down_reg);
                m_tr_reg <= mix4(center, right, s1_down_reg);
                m_bl_reg <= mix4(center, left_reg, up);
                m_br_reg <= mix4(center, right, up);
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_src_col      = m_col_reg;
    assign m_src_row      = m_row_reg;
    assign m_top_left     = m_tl_reg;
    assign m_top_right    = m_tr_reg;
    assign m_bottom_left  = m_bl_reg;
    assign m_bottom_right = m_br_reg;
    assign m_on_border    = m_border_reg;
    assign m_frame_last   = m_last_reg;

`ifndef NO_ASSERTIONS
    // output side lags input side by exactly one row while pixels arrive
    a_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        (store_wr && in_row_reg != '0) |->
            (HW'(out_row_reg) + HW'(1) == in_row_reg) && (out_col_reg == in_col_reg))
        else $error("output position out of step with input position");

    // a completed frame leaves the input column at zero
    a_done_col: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_done_reg |-> (in_col_reg == '0))
        else $error("frame done with partial input row");

    // an emitted request always lands in the mix stage
    a_emit_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> s1_valid_reg)
        else $error("emitted block lost before mix stage");

    // a blocked mix stage holds its block
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !out_adv) |=> (s1_valid_reg && $stable(s1_col_reg)
                                         && $stable(s1_row_reg)))
        else $error("mix stage changed while stalled");

    // interior blocks never sit on column or row zero
    a_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_border_reg) |-> (m_col_reg != '0) && (m_row_reg != '0))
        else $error("interior block at image edge");
`endif

endmodule

// ===== dv/pixel_upscale_2x_interp_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_upscale_2x_interp_unit_tb
// Self-checking regression of the 2x bilinear upscaler. A scoreboard class
// mirrors the line stores and the frame counters, turns each accepted request
// that should cause a 2x2 block into that block and compares each block leaving
// m_ field by field. Directed frames cover the corners, then frames of random
// size and content run with random gaps, stalls and dropped requests.
// ----------------------------------------------------------------------------
module pixel_upscale_2x_interp_unit_tb;
    import pu2x_pkg::*;

    localparam int          CLK_PERIOD  = 10;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned SETTLE      = 8;
    localparam int unsigned RAND_ITEMS  = 550;
    localparam int unsigned MIN_PHASES  = 10;

    // 3x3 frame: one interior pixel, saturated and empty channels around it
    localparam logic [PIX_W-1:0] CORNER_PX [9] = '{
        32'hFFFFFFFF, 32'h00000000, 32'h80FF7F01,
        32'h00000000, 32'hFFFFFFFF, 32'h01020304,
        32'hFFFFFFFF, 32'h00FF00FF, 32'h12345678
    };

    typedef struct packed {
        logic [COORD_W-1:0] src_col;
        logic [COORD_W-1:0] src_row;
        logic [PIX_W-1:0]   top_left;
        logic [PIX_W-1:0]   top_right;
        logic [PIX_W-1:0]   bottom_left;
        logic [PIX_W-1:0]   bottom_right;
        logic               on_border;
        logic               frame_last;
    } block_t;

    class upscale_scoreboard;
        logic [PIX_W-1:0] line_mem [2][MAX_WIDTH_DEF];
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        int unsigned      in_col;
        int unsigned      in_row;
        int unsigned      out_col;
        int unsigned      out_row;
        bit               frame_done;
        block_t           block_q[$];
        int unsigned      mismatches;
        int unsigned      live_requests;

        function new();
            foreach (line_mem[b, i]) line_mem[b][i] = '0;
            width_reg     = WIDTH_RST;
            height_reg    = HEIGHT_RST;
            mismatches    = 0;
            live_requests = 0;
            restart();
        endfunction

        function void restart();
            in_col     = 0;
            in_row     = 0;
            out_col    = 0;
            out_row    = 0;
            frame_done = 1'b0;
        endfunction

        function int unsigned clamp_size(logic [CFG_W-1:0] v, int unsigned hi);
            if (v == '0) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function int unsigned frame_width();
            return clamp_size(width_reg, MAX_WIDTH_DEF);
        endfunction

        function int unsigned frame_height();
            return clamp_size(height_reg, MAX_HEIGHT);
        endfunction

        function void write_reg(logic idx, logic [CFG_W-1:0] val);
            if (idx == REG_WIDTH) width_reg = val;
            else height_reg = val;
            restart();
        endfunction

        // per channel floor((2p + a + b) / 4)
        function logic [PIX_W-1:0] blend(logic [PIX_W-1:0] p, logic [PIX_W-1:0] a,
                                         logic [PIX_W-1:0] b);
            logic [PIX_W-1:0] r;
            logic [9:0]       sum;
            for (int s = 0; s < PIX_W; s += 8) begin
                sum = 10'({p[s +: 8], 1'b0}) + 10'(a[s +: 8]) + 10'(b[s +: 8]);
                r[s +: 8] = sum[9:2];
            end
            return r;
        endfunction

        function void push_block(logic [PIX_W-1:0] up, logic [PIX_W-1:0] down);
            int unsigned      w;
            int unsigned      h;
            int unsigned      x;
            int unsigned      y;
            bit               border;
            bit               last;
            logic [PIX_W-1:0] p;
            block_t           blk;
            w = frame_width();
            h = frame_height();
            x = out_col % w;
            y = out_row % h;
            p = line_mem[y % 2][x];
            border = (x == 0) || (x + 1 >= w) || (y == 0) || (y + 1 >= h);
            last   = (x + 1 >= w) && (y + 1 >= h);
            blk.src_col = COORD_W'(x);
            blk.src_row = COORD_W'(y);
            if (border) begin
                blk.top_left     = p;
                blk.top_right    = p;
                blk.bottom_left  = p;
                blk.bottom_right = p;
            end else begin
                blk.top_left     = blend(p, line_mem[y % 2][x - 1], down);
                blk.top_right    = blend(p, line_mem[y % 2][x + 1], down);
                blk.bottom_left  = blend(p, line_mem[y % 2][x - 1], up);
                blk.bottom_right = blend(p, line_mem[y % 2][x + 1], up);
            end
            blk.on_border  = border;
            blk.frame_last = last;
            block_q.push_back(blk);
            if (last) begin
                restart();
                return;
            end
            out_col = x + 1;
            out_row = y;
            if (out_col >= w) begin
                out_col = 0;
                out_row = y + 1;
            end
        endfunction

        function void note_request(logic op, logic [PIX_W-1:0] pix);
            int unsigned w;
            int unsigned h;
            int unsigned x;
            int unsigned r;
            if (op == OP_FLUSH) begin
                // drop flushes until the whole frame is in
                if (frame_done) begin
                    live_requests++;
                    push_block('0, '0);
                end
                return;
            end
            if (frame_done) return;
            live_requests++;
            w = frame_width();
            h = frame_height();
            x = in_col % w;
            r = in_row % h;
            // the store entry still holds row r-2: the up neighbour of row r-1
            if (r >= 1) push_block(line_mem[r % 2][x], pix);
            line_mem[r % 2][x] = pix;
            in_col = x + 1;
            in_row = r;
            if (in_col >= w) begin
                in_col = 0;
                in_row = r + 1;
                if (in_row >= h) frame_done = 1'b1;
            end
        endfunction

        function void compare_field(string name, logic [PIX_W-1:0] want,
                                    logic [PIX_W-1:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s mismatch: expected %08h, actual %08h",
                         $time, name, want, got);
            end
        endfunction

        function void check_block(block_t got);
            block_t want;
            if (block_q.size() == 0) begin
                mismatches++;
                $display("%0t: block mismatch: expected none, actual col %0d row %0d",
                         $time, got.src_col, got.src_row);
                return;
            end
            want = block_q.pop_front();
            compare_field("src_col",      want.src_col,      got.src_col);
            compare_field("src_row",      want.src_row,      got.src_row);
            compare_field("top_left",     want.top_left,     got.top_left);
            compare_field("top_right",    want.top_right,    got.top_right);
            compare_field("bottom_left",  want.bottom_left,  got.bottom_left);
            compare_field("bottom_right", want.bottom_right, got.bottom_right);
            compare_field("on_border",    want.on_border,    got.on_border);
            compare_field("frame_last",   want.frame_last,   got.frame_last);
        endfunction

        function int unsigned pending();
            return block_q.size();
        endfunction
    endclass

    logic                 aclk           = 1'b0;
    logic                 aresetn        = 1'b0;
    logic                 cfg_we         = 1'b0;
    logic                 cfg_index      = REG_WIDTH;
    logic [CFG_W-1:0]     cfg_data       = '0;
    logic                 s_valid        = 1'b0;
    logic                 s_ready;
    logic                 s_operation    = OP_PIXEL;
    logic [PIX_W-1:0]     s_pixel_rgba   = '0;
    logic                 m_valid;
    logic                 m_ready        = 1'b0;
    logic [COORD_W-1:0]   m_src_col;
    logic [COORD_W-1:0]   m_src_row;
    logic [PIX_W-1:0]     m_top_left;
    logic [PIX_W-1:0]     m_top_right;
    logic [PIX_W-1:0]     m_bottom_left;
    logic [PIX_W-1:0]     m_bottom_right;
    logic                 m_on_border;
    logic                 m_frame_last;

    bit                   src_idle       = 1'b1;
    bit                   sink_idle      = 1'b1;
    bit                   hold_off       = 1'b0;
    int unsigned          cycle_count    = 0;
    upscale_scoreboard    sb;

    pixel_upscale_2x_interp_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_pixel_rgba   (s_pixel_rgba),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_src_col      (m_src_col),
        .m_src_row      (m_src_row),
        .m_top_left     (m_top_left),
        .m_top_right    (m_top_right),
        .m_bottom_left  (m_bottom_left),
        .m_bottom_right (m_bottom_right),
        .m_on_border    (m_on_border),
        .m_frame_last   (m_frame_last)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_request(s_operation, s_pixel_rgba);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_block('{m_src_col, m_src_row, m_top_left, m_top_right,
                             m_bottom_left, m_bottom_right, m_on_border, m_frame_last});
        end
    end

    // receiver: random backpressure in idle phases, always ready otherwise, or one long hold-off when asked
    initial begin
        int unsigned held;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge aclk);
                    held++;
                end
                hold_off = 1'b0;
            end else if (sink_idle) begin
                m_ready <= ($urandom_range(0, 99) >= 25);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("pixel_upscale_2x_interp_unit regression: fail");
        $finish;
    end

    function automatic logic [PIX_W-1:0] rand_pixel();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) return '1;
        if (pick < 14) return '0;
        if (pick < 24) return $urandom() | 32'hF0F0F0F0;
        return $urandom();
    endfunction

    task automatic send_req(input logic op, input logic [PIX_W-1:0] pix);
        if (src_idle && $urandom_range(0, 99) < 25) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_pixel_rgba <= pix;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic send_pixels(input int unsigned n, input bit noisy);
        for (int unsigned i = 0; i < n; i++) begin
            // early flush: dropped by the block
            if (noisy && $urandom_range(0, 99) < 4) send_req(OP_FLUSH, $urandom());
            send_req(OP_PIXEL, rand_pixel());
        end
    endtask

    task automatic send_frame(input int unsigned w, input int unsigned h, input bit noisy);
        send_pixels(w * h, noisy);
        if (noisy && $urandom_range(0, 99) < 30) begin
            repeat ($urandom_range(1, 3)) send_req(OP_PIXEL, rand_pixel());
        end
        repeat (w) send_req(OP_FLUSH, $urandom());
        if (noisy && $urandom_range(0, 99) < 20) send_req(OP_FLUSH, $urandom());
    endtask

    // stop offering, wait for every block, then let the pipeline settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic program_frame(input bit set_w, input logic [CFG_W-1:0] w_val,
                                 input bit set_h, input logic [CFG_W-1:0] h_val);
        if (set_w) begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_WIDTH;
            cfg_data  <= w_val;
            @(posedge aclk);
            sb.write_reg(REG_WIDTH, w_val);
        end
        if (set_h) begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_HEIGHT;
            cfg_data  <= h_val;
            @(posedge aclk);
            sb.write_reg(REG_HEIGHT, h_val);
        end
        cfg_we <= 1'b0;
    endtask

    initial begin
        int unsigned      w;
        int unsigned      h;
        int unsigned      n;
        int unsigned      frames;
        int unsigned      start_count;
        int unsigned      phase;
        int unsigned      which;
        int unsigned      pick;
        logic [CFG_W-1:0] w_val;
        logic [CFG_W-1:0] h_val;

        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        program_frame(1'b1, CFG_W'(3), 1'b1, CFG_W'(3));
        send_req(OP_FLUSH, 32'hDEADBEEF);
        foreach (CORNER_PX[i]) send_req(OP_PIXEL, CORNER_PX[i]);
        send_req(OP_PIXEL, 32'h5A5A5A5A);
        repeat (4) send_req(OP_FLUSH, 32'hFFFFFFFF);
        wait_idle();
        program_frame(1'b1, CFG_W'(1), 1'b1, CFG_W'(2));
        send_frame(1, 2, 1'b0);
        wait_idle();
        program_frame(1'b1, CFG_W'(2), 1'b1, CFG_W'(1));
        send_frame(2, 1, 1'b0);
        wait_idle();

        // out-of-range registers: the row closes at the line store depth,
        // so the next pixels open row 1 and give blocks; then abandon the frame
        program_frame(1'b1, '1, 1'b1, '1);
        send_pixels(sb.frame_width() + 2, 1'b0);
        wait_idle();

        start_count = sb.live_requests;
        phase = 0;
        while (sb.live_requests - start_count < RAND_ITEMS || phase < MIN_PHASES) begin
            src_idle  = !(phase >= 6 && phase < 10);
            sink_idle = src_idle;
            if (phase == 3) begin
                program_frame(1'b1, CFG_W'(12), 1'b1, CFG_W'(5));
                hold_off = 1'b1;
            end else begin
                pick  = $urandom_range(0, 99);
                w_val = (pick < 8)  ? '0 :
                        (pick < 18) ? CFG_W'($urandom_range(9, 40)) :
                                      CFG_W'($urandom_range(1, 8));
                h_val = ($urandom_range(0, 99) < 8) ? '0 : CFG_W'($urandom_range(1, 6));
                which = (phase == 0) ? 2 : $urandom_range(0, 5);
                program_frame(which != 1, w_val, which != 0, h_val);
            end
            w = sb.frame_width();
            h = sb.frame_height();
            frames = $urandom_range(1, 3);
            for (int unsigned f = 0; f < frames; f++) begin
                if (phase != 3 && $urandom_range(0, 99) < 12) begin
                    // broken frame: stop partway, the next register write restarts it
                    n = $urandom_range(1, w * h);
                    send_pixels(n, 1'b1);
                    if (n == w * h) repeat ($urandom_range(0, w - 1)) send_req(OP_FLUSH, $urandom());
                    break;
                end
                send_frame(w, h, 1'b1);
            end
            wait_idle();
            phase++;
        end

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("pixel_upscale_2x_interp_unit regression: pass");
        end else begin
            $display("pixel_upscale_2x_interp_unit regression: fail");
        end
        $finish;
    end
endmodule
